### src/afc_pkg.sv
// Package for the assignment feasibility check unit.
// Holds the shared constants, the column label type and the controller/datapath
// command and status structs. It depends on nothing else.
`default_nettype none

package afc_pkg;

   localparam int MAX_N_DEFAULT = 32;
   localparam int COUNT_W       = 6;
   localparam int MASK_W        = 32;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_UNIQUE = 2'd1,
      KIND_MULTI  = 2'd2
   } kind_type;

   typedef struct packed {
      logic take_row;
      logic start_check;
      logic walk_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic walk_done;
   } status_type;

endpackage

`default_nettype wire

### src/afc_req_if.sv
// Input channel interface of the assignment feasibility check unit.
// Carries one matrix row per transaction; depends on afc_pkg for field widths.
`default_nettype none

interface afc_req_if;
   logic                          valid;
   logic                          ready;
   logic [afc_pkg::COUNT_W-1:0]   row_count;
   logic [afc_pkg::COUNT_W-1:0]   col_count;
   logic [afc_pkg::MASK_W-1:0]    finite_mask;
   logic                          last_row;

   modport source (output valid, output row_count, output col_count,
                   output finite_mask, output last_row, input ready);
   modport sink   (input valid, input row_count, input col_count,
                   input finite_mask, input last_row, output ready);
endinterface

`default_nettype wire

### src/afc_rsp_if.sv
// Result channel interface of the assignment feasibility check unit.
// Carries the solvable verdict of one matrix; depends on nothing else.
`default_nettype none

interface afc_rsp_if;
   logic valid;
   logic ready;
   logic solvable;

   modport source (output valid, output solvable, input ready);
   modport sink   (input valid, input solvable, output ready);
endinterface

`default_nettype wire

### src/afc_ctrl.sv
// Controller state machine of the assignment feasibility check unit.
// Sequences row intake, the final column walk and the result hand-off; uses afc_pkg.
`default_nettype none

module afc_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_last,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire afc_pkg::status_type status,
   output afc_pkg::cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CHECK = 4'b0010,
      ST_WALK  = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take_row = 1'b1;
               if (req_last) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            cmd.start_check = 1'b1;
            state_in        = ST_WALK;
         end
         ST_WALK: begin
            if (status.walk_done) begin
               state_in = ST_EMIT;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         ST_EMIT: begin
            // The result register is free once any earlier verdict has been taken.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### src/afc_dp.sv
// Datapath of the assignment feasibility check unit.
// Holds the column labels, row bookkeeping, the column walk and the result register;
// uses afc_pkg and is driven by afc_ctrl.
`default_nettype none

module afc_dp #(
   parameter int MAX_N = afc_pkg::MAX_N_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire afc_pkg::cmd_type            cmd,
   output afc_pkg::status_type              status,
   input  wire logic [afc_pkg::COUNT_W-1:0] row_count,
   input  wire logic [afc_pkg::COUNT_W-1:0] col_count,
   input  wire logic [afc_pkg::MASK_W-1:0]  finite_mask,
   output logic                             solvable
);

   localparam int IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
   localparam int CW = $clog2(MAX_N + 1);
   localparam int MW = (MAX_N > afc_pkg::MASK_W) ? MAX_N : afc_pkg::MASK_W;
   // Wide enough to compare any count against MAX_N or a column number.
   localparam int XW = ((CW > afc_pkg::COUNT_W) ? CW : afc_pkg::COUNT_W) + 1;

   afc_pkg::kind_type          kind_ff  [MAX_N];
   afc_pkg::kind_type          kind_in  [MAX_N];
   logic [IW-1:0]              owner_ff [MAX_N];
   logic [IW-1:0]              owner_in [MAX_N];
   logic [MAX_N-1:0]           claimed_ff, claimed_in;
   logic [afc_pkg::COUNT_W-1:0] rows_ff, rows_in;
   logic                       empty_ff, empty_in;
   logic                       overrun_ff, overrun_in;
   logic [afc_pkg::COUNT_W-1:0] nrows_ff, nrows_in;
   logic [afc_pkg::COUNT_W-1:0] ncols_ff, ncols_in;
   logic [CW-1:0]              col_ff, col_in;
   logic                       fail_ff, fail_in;
   logic                       solvable_ff, solvable_in;

   logic [MW-1:0]              mask_ext;
   logic [MAX_N-1:0]           hit;
   logic                       row_in_range;
   logic                       precheck_fail;
   afc_pkg::kind_type          walk_kind;
   logic [IW-1:0]              walk_owner;

   assign mask_ext     = MW'(finite_mask);
   assign row_in_range = (XW'(rows_ff) < XW'(MAX_N));

   always_comb begin
      for (int j = 0; j < MAX_N; j++) begin
         hit[j] = mask_ext[j] && (XW'(j) < XW'(col_count));
      end
   end

   assign precheck_fail = (nrows_ff != ncols_ff) || (nrows_ff == '0)
                        || (XW'(nrows_ff) > XW'(MAX_N)) || overrun_ff
                        || (rows_ff != nrows_ff) || empty_ff;

   assign walk_kind  = kind_ff[col_ff[IW-1:0]];
   assign walk_owner = owner_ff[col_ff[IW-1:0]];
   assign status.walk_done = fail_ff || (XW'(col_ff) >= XW'(ncols_ff));

   always_comb begin
      kind_in     = kind_ff;
      owner_in    = owner_ff;
      claimed_in  = claimed_ff;
      rows_in     = rows_ff;
      empty_in    = empty_ff;
      overrun_in  = overrun_ff;
      nrows_in    = nrows_ff;
      ncols_in    = ncols_ff;
      col_in      = col_ff;
      fail_in     = fail_ff;
      solvable_in = solvable_ff;

      if (cmd.take_row) begin
         nrows_in = row_count;
         ncols_in = col_count;
         if (hit == '0) begin
            empty_in = 1'b1;
         end
         if (rows_ff == afc_pkg::COUNT_MAX) begin
            overrun_in = 1'b1;
         end else begin
            rows_in = rows_ff + 1'b1;
         end
         for (int j = 0; j < MAX_N; j++) begin
            if (hit[j] && row_in_range) begin
               if (kind_ff[j] == afc_pkg::KIND_NONE) begin
                  kind_in[j]  = afc_pkg::KIND_UNIQUE;
                  owner_in[j] = rows_ff[IW-1:0];
               end else begin
                  kind_in[j]  = afc_pkg::KIND_MULTI;
               end
            end
         end
      end

      if (cmd.start_check) begin
         fail_in = precheck_fail;
         col_in  = '0;
      end

      if (cmd.walk_step) begin
         col_in = col_ff + 1'b1;
         case (walk_kind)
            afc_pkg::KIND_NONE: begin
               fail_in = 1'b1;
            end
            afc_pkg::KIND_UNIQUE: begin
               if (claimed_ff[walk_owner]) begin
                  fail_in = 1'b1;
               end else begin
                  claimed_in[walk_owner] = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.finish) begin
         solvable_in = !fail_ff;
         for (int j = 0; j < MAX_N; j++) begin
            kind_in[j] = afc_pkg::KIND_NONE;
         end
         claimed_in = '0;
         rows_in    = '0;
         empty_in   = 1'b0;
         overrun_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < MAX_N; j++) begin
            kind_ff[j] <= afc_pkg::KIND_NONE;
         end
         claimed_ff <= '0;
         rows_ff    <= '0;
         empty_ff   <= 1'b0;
         overrun_ff <= 1'b0;
         fail_ff    <= 1'b0;
         col_ff     <= '0;
      end else begin
         kind_ff    <= kind_in;
         claimed_ff <= claimed_in;
         rows_ff    <= rows_in;
         empty_ff   <= empty_in;
         overrun_ff <= overrun_in;
         fail_ff    <= fail_in;
         col_ff     <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      owner_ff    <= owner_in;
      nrows_ff    <= nrows_in;
      ncols_ff    <= ncols_in;
      solvable_ff <= solvable_in;
   end

   assign solvable = solvable_ff;

endmodule

`default_nettype wire

### src/assignment_feasibility_check_unit.sv
// Assignment feasibility check unit: screens a square cost matrix, delivered one
// row per transaction as a bitmask of its finite entries, before an assignment solver
// runs, and gives one solvable verdict per matrix on the transaction marked last_row.
// An ordinary row is taken and the block is ready for the next row in the following
// cycle, since all column labels are updated in parallel. For the last row, the steps
// before its verdict is registered are: taking the row, the count checks, the walk
// through the column labels, one label per cycle (which stops early at the first
// failure), a state in which the controller sees that the walk has ended, and the
// loading of the result register with the clearing of all state for the next
// matrix. A verdict waiting in the result register does not stop the rows of the next
// matrix from being taken, but that matrix's own verdict cannot be loaded until the
// earlier one has been taken, and no rows are accepted while it waits.
// Depends on afc_pkg, afc_req_if, afc_rsp_if, afc_ctrl and afc_dp.
`default_nettype none

module assignment_feasibility_check_unit #(
   parameter int MAX_N = afc_pkg::MAX_N_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   afc_req_if.sink    req,
   afc_rsp_if.source  rsp
);

   afc_pkg::cmd_type    cmd;
   afc_pkg::status_type status;

   // The controller owns the handshakes; the datapath only sees commands.
   afc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_last  (req.last_row),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   afc_dp #(
      .MAX_N (MAX_N)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .row_count   (req.row_count),
      .col_count   (req.col_count),
      .finite_mask (req.finite_mask),
      .solvable    (rsp.solvable)
   );

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for assignment_feasibility_check_unit: row transactions go in with
// random pacing, and each verdict is checked against an in-bench screen of the matrix.
// Depends on afc_pkg, afc_req_if, afc_rsp_if and the unit itself.

module tb;

   localparam int N_MAX   = afc_pkg::MAX_N_DEFAULT;
   localparam int OWNER_W = $clog2(N_MAX);
   // The quiet limit lies above the longest receiver hold-off, so reaching it can only
   // mean a hang.
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 100;

   typedef struct {
      logic [afc_pkg::COUNT_W-1:0] row_count;
      logic [afc_pkg::COUNT_W-1:0] col_count;
      logic [afc_pkg::MASK_W-1:0]  finite_mask;
      logic                        last_row;
      bit                          wait_drain;   // hold this row back until every verdict is in
   } row_txn_type;

   typedef struct {
      bit solvable;
      int matrix_no;
   } verdict_type;

   // Matrix shapes. Only the first is well formed; the others break one rule each.
   typedef enum int {
      SHAPE_GOOD, SHAPE_SHORT, SHAPE_LONG, SHAPE_EMPTY_ROW, SHAPE_EMPTY_COL, SHAPE_TWIN,
      SHAPE_SKEW, SHAPE_DRIFT, SHAPE_BIG, SHAPE_OVERRUN, SHAPE_ZERO
   } shape_type;

   logic clock;
   logic reset;

   afc_req_if req_if ();
   afc_rsp_if rsp_if ();

   assignment_feasibility_check_unit DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   always #5 clock = ~clock;

   row_txn_type rows_to_send [$];
   verdict_type verdicts_due [$];
   int          fails;

   // Screening state of the matrix in progress, mirroring what the unit keeps.
   afc_pkg::kind_type           col_kind   [N_MAX];
   logic [OWNER_W-1:0]          col_owner  [N_MAX];
   logic [afc_pkg::COUNT_W-1:0] rows_seen;
   bit                          empty_seen;
   bit                          count_overrun;

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      fails++;
   endtask

   function automatic void clear_screen();
      foreach (col_kind[j]) begin
         col_kind[j]  = afc_pkg::KIND_NONE;
         col_owner[j] = '0;
      end
      rows_seen     = '0;
      empty_seen    = 1'b0;
      count_overrun = 1'b0;
   endfunction

   // Folds one accepted row into the column labels. On the last row it also works out
   // the verdict, and then clears the state for the next matrix.
   function automatic void screen_row(input logic [afc_pkg::COUNT_W-1:0] rc,
                                      input logic [afc_pkg::COUNT_W-1:0] cc,
                                      input logic [afc_pkg::MASK_W-1:0]  mask,
                                      input logic                        last,
                                      output bit                         has_verdict,
                                      output bit                         ok);
      int limit;
      int row;
      int r;
      bit any;
      bit claimed [N_MAX];
      limit = (cc < N_MAX) ? int'(cc) : N_MAX;
      row   = int'(rows_seen);
      any   = 1'b0;
      for (int j = 0; j < limit; j++) begin
         if (mask[j]) begin
            any = 1'b1;
            // Rows numbered past the label capacity count, but label nothing.
            if (row < N_MAX) begin
               if (col_kind[j] == afc_pkg::KIND_NONE) begin
                  col_kind[j]  = afc_pkg::KIND_UNIQUE;
                  col_owner[j] = OWNER_W'(row);
               end else if (col_kind[j] == afc_pkg::KIND_UNIQUE) begin
                  col_kind[j]  = afc_pkg::KIND_MULTI;
                  col_owner[j] = '0;
               end
            end
         end
      end
      if (!any)
         empty_seen = 1'b1;
      if (rows_seen == afc_pkg::COUNT_MAX)
         count_overrun = 1'b1;
      else
         rows_seen++;

      has_verdict = last;
      ok          = 1'b0;
      if (!last)
         return;

      ok = (rc == cc) && (rc != 0) && (rc <= N_MAX) && !count_overrun &&
           (rows_seen == rc) && !empty_seen;
      foreach (claimed[i])
         claimed[i] = 1'b0;
      // A row may own at most one column that nobody else can fill.
      for (int j = 0; ok && j < int'(cc); j++) begin
         if (col_kind[j] == afc_pkg::KIND_NONE) begin
            ok = 1'b0;
         end else if (col_kind[j] == afc_pkg::KIND_UNIQUE) begin
            r = int'(col_owner[j]);
            if (claimed[r])
               ok = 1'b0;
            claimed[r] = 1'b1;
         end
      end
      clear_screen();
   endfunction

   task automatic queue_row(input int rc, input int cc,
                            input logic [afc_pkg::MASK_W-1:0] mask,
                            input bit last, input bit drain);
      row_txn_type t;
      t.row_count   = afc_pkg::COUNT_W'(rc);
      t.col_count   = afc_pkg::COUNT_W'(cc);
      t.finite_mask = mask;
      t.last_row    = last;
      t.wait_drain  = drain;
      rows_to_send.push_back(t);
   endtask

   // Builds one matrix. The base is a random permutation plus random extra entries, which
   // is always solvable; the shape then breaks it in one particular way. Mask bits past
   // the column count are sometimes filled with noise, which the unit must ignore.
   task automatic queue_matrix(input shape_type shape, input int size, input bit drain);
      logic [afc_pkg::MASK_W-1:0] rows_m [72];
      logic [63:0]                upper;
      int order [N_MAX];
      int nrows, rc, cc, cc_row, dens, a, b, r, s, t, tmp;
      nrows = size;
      rc    = size;
      cc    = size;
      for (int i = 0; i < size; i++)
         order[i] = i;
      for (int i = size - 1; i > 0; i--) begin
         t        = $urandom_range(0, i);
         tmp      = order[i];
         order[i] = order[t];
         order[t] = tmp;
      end
      upper = ~((64'd1 << size) - 64'd1);
      dens  = $urandom_range(0, 3);
      for (int i = 0; i < 72; i++) begin
         if (i < size) begin
            rows_m[i] = $urandom_range(0, 1) ? ($urandom & upper[afc_pkg::MASK_W-1:0])
                                             : '0;
            rows_m[i][order[i]] = 1'b1;
            for (int j = 0; j < size; j++)
               if ($urandom_range(0, 7) < dens)
                  rows_m[i][j] = 1'b1;
         end else begin
            rows_m[i] = ($urandom_range(0, 4) == 0) ? '0 : afc_pkg::MASK_W'($urandom);
         end
      end

      case (shape)
         SHAPE_SHORT: begin
            if (size > 1) begin
               nrows = size - 1;
            end else begin
               rc = size + 1;
               cc = size + 1;
            end
         end
         SHAPE_LONG:  nrows = size + $urandom_range(1, 2);
         SHAPE_EMPTY_ROW: begin
            r = $urandom_range(0, size - 1);
            rows_m[r] = rows_m[r] & upper[afc_pkg::MASK_W-1:0];
         end
         SHAPE_EMPTY_COL: begin
            a = $urandom_range(0, size - 1);
            for (int i = 0; i < size; i++)
               rows_m[i][a] = 1'b0;
         end
         SHAPE_TWIN: begin
            // Row r keeps its own column and takes row s's as well; s falls back on a
            // third row's column, so only the double claim can fail the matrix.
            r = $urandom_range(0, size - 1);
            s = (r + $urandom_range(1, size - 1)) % size;
            a = order[r];
            b = order[s];
            for (int i = 0; i < size; i++) begin
               if (i != r) begin
                  rows_m[i][a] = 1'b0;
                  rows_m[i][b] = 1'b0;
               end
            end
            rows_m[r][b] = 1'b1;
            t = (r + 1) % size;
            if (t == s)
               t = (t + 1) % size;
            rows_m[s][order[t]] = 1'b1;
         end
         SHAPE_SKEW: begin
            if ($urandom_range(0, 1))
               cc = $urandom_range(0, 63);
            else
               rc = $urandom_range(0, 63);
         end
         SHAPE_BIG: begin
            nrows = size + $urandom_range(1, 5);
            rc    = $urandom_range(0, 1) ? size : nrows;
            cc    = rc;
         end
         SHAPE_OVERRUN: begin
            nrows = $urandom_range(63, 68);
            rc    = $urandom_range(0, 1) ? 63 : $urandom_range(1, 63);
            cc    = rc;
         end
         SHAPE_ZERO: begin
            case ($urandom_range(0, 2))
               0: rc = 0;
               1: cc = 0;
               default: begin
                  rc = 0;
                  cc = 0;
               end
            endcase
         end
         default: ;
      endcase

      for (int i = 0; i < nrows; i++) begin
         // Drifting counts: earlier rows may carry a column count of their own.
         cc_row = (shape == SHAPE_DRIFT && i != nrows - 1 && $urandom_range(0, 1)) ?
                  $urandom_range(0, 63) : cc;
         queue_row(rc, cc_row, rows_m[i], i == nrows - 1, drain && i == 0);
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Driver. It takes rows from the pending queue in bursts of random length separated by
   // random gaps. When a row is accepted it is folded into the screen straight away, so
   // the expected verdict is queued in acceptance order.
   // ---------------------------------------------------------------------------------------
   int burst_left;
   int gap_left;
   int matrices_sent;

   always @(posedge clock) begin : send
      bit fire;
      bit has_verdict;
      bit ok;
      verdict_type v;
      if (reset) begin
         req_if.valid  <= 1'b0;
         burst_left    = 0;
         gap_left      = 0;
         matrices_sent = 0;
         clear_screen();
      end else begin
         fire = req_if.valid && req_if.ready;
         if (fire) begin
            void'(rows_to_send.pop_front());
            screen_row(req_if.row_count, req_if.col_count, req_if.finite_mask,
                       req_if.last_row, has_verdict, ok);
            if (has_verdict) begin
               matrices_sent++;
               v.solvable  = ok;
               v.matrix_no = matrices_sent;
               verdicts_due.push_back(v);
            end
         end
         // A row on offer stays on offer, unchanged, until it is taken.
         if (!req_if.valid || fire) begin
            if (burst_left == 0 && gap_left == 0) begin
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(1, 10);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (rows_to_send.size() != 0 &&
                         !(rows_to_send[0].wait_drain && verdicts_due.size() != 0)) begin
               req_if.valid       <= 1'b1;
               req_if.row_count   <= rows_to_send[0].row_count;
               req_if.col_count   <= rows_to_send[0].col_count;
               req_if.finite_mask <= rows_to_send[0].finite_mask;
               req_if.last_row    <= rows_to_send[0].last_row;
               if (burst_left > 0)
                  burst_left--;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Monitor. Every verdict taken is compared with the oldest one expected. The ready
   // pattern changes mode every so often: always ready, mostly ready or mostly stalled.
   // Twice in the run it holds off for a long stretch, so that a verdict sits in the
   // result register and the next matrix's verdict has to wait for it.
   // ---------------------------------------------------------------------------------------
   int hold_left;
   int phase_left;
   int stall_mode;
   int verdicts_seen;

   always @(posedge clock) begin : receive
      verdict_type due;
      if (reset) begin
         rsp_if.ready  <= 1'b0;
         hold_left     = 0;
         phase_left    = 0;
         stall_mode    = 0;
         verdicts_seen = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (verdicts_due.size() == 0) begin
               report_mismatch($sformatf("verdict %b with no matrix outstanding",
                                         rsp_if.solvable));
            end else begin
               due = verdicts_due.pop_front();
               if (rsp_if.solvable !== due.solvable)
                  report_mismatch($sformatf("matrix %0d: solvable %b, expected %b",
                                            due.matrix_no, rsp_if.solvable, due.solvable));
            end
            verdicts_seen++;
            if (verdicts_seen == 10 || verdicts_seen == 60)
               hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            if (phase_left == 0) begin
               stall_mode = $urandom_range(0, 2);
               phase_left = $urandom_range(20, 120);
            end else begin
               phase_left--;
            end
            case (stall_mode)
               0:       rsp_if.ready <= 1'b1;
               1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
               default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Watchdog: any cycle with a transaction on either channel restarts the count.
   int quiet_cycles;

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL assignment_feasibility_check_unit");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus and end of run.
   // ---------------------------------------------------------------------------------------
   initial begin
      int k;
      int size;
      int p;
      shape_type shape;
      clock              = 1'b0;
      reset              = 1'b1;
      fails              = 0;
      req_if.valid       = 1'b0;
      req_if.row_count   = '0;
      req_if.col_count   = '0;
      req_if.finite_mask = '0;
      req_if.last_row    = 1'b0;
      rsp_if.ready       = 1'b0;

      // Directed matrices. A one-by-one matrix with its single entry finite is solvable.
      queue_row(1, 1, 32'h0000_0001, 1, 0);
      // The only column is clear, while every ignored bit above it is set: an empty row.
      queue_row(1, 1, 32'hFFFF_FFFE, 1, 0);
      // Zero counts, differing counts, and counts above the maximum.
      queue_row(0, 0, 32'hFFFF_FFFF, 1, 0);
      queue_row(1, 2, 32'h0000_0003, 1, 0);
      queue_row(33, 33, 32'hFFFF_FFFF, 1, 0);
      queue_row(63, 63, 32'h0000_0000, 1, 0);
      // Two-by-two identity, then every entry finite: both solvable.
      queue_row(2, 2, 32'h0000_0001, 0, 0);
      queue_row(2, 2, 32'h0000_0002, 1, 0);
      queue_row(2, 2, 32'h0000_0003, 0, 0);
      queue_row(2, 2, 32'h0000_0003, 1, 0);
      // Columns 0 and 1 are both unique to row 0.
      queue_row(3, 3, 32'h0000_0003, 0, 0);
      queue_row(3, 3, 32'h0000_0004, 0, 0);
      queue_row(3, 3, 32'h0000_0004, 1, 0);
      // Column 1 is never finite.
      queue_row(2, 2, 32'h0000_0001, 0, 0);
      queue_row(2, 2, 32'h0000_0001, 1, 0);
      // One row short of the count.
      queue_row(3, 3, 32'h0000_0001, 0, 0);
      queue_row(3, 3, 32'h0000_0002, 1, 0);
      // The first row carries a column count of one, so its only set bit is ignored.
      queue_row(2, 1, 32'h0000_0002, 0, 0);
      queue_row(2, 2, 32'h0000_0003, 1, 0);

      // Random matrices, mostly well formed and small. A matrix with rows past the
      // label capacity and one that fills or overflows the row counter come early on purpose, and
      // every fifteenth matrix waits until the unit has delivered all verdicts.
      k = 0;
      while (rows_to_send.size() < 770) begin
         p = $urandom_range(0, 99);
         if (p < 55)      shape = SHAPE_GOOD;
         else if (p < 60) shape = SHAPE_SHORT;
         else if (p < 65) shape = SHAPE_LONG;
         else if (p < 70) shape = SHAPE_EMPTY_ROW;
         else if (p < 75) shape = SHAPE_EMPTY_COL;
         else if (p < 82) shape = SHAPE_TWIN;
         else if (p < 87) shape = SHAPE_SKEW;
         else if (p < 93) shape = SHAPE_DRIFT;
         else if (p < 96) shape = SHAPE_BIG;
         else if (p < 97) shape = SHAPE_OVERRUN;
         else             shape = SHAPE_ZERO;
         if (k == 5)
            shape = SHAPE_BIG;
         if (k == 12)
            shape = SHAPE_OVERRUN;
         p = $urandom_range(0, 99);
         if (p < 70)      size = $urandom_range(1, 6);
         else if (p < 95) size = $urandom_range(7, 16);
         else             size = $urandom_range(17, 32);
         if (shape == SHAPE_BIG)
            size = N_MAX;
         if (shape == SHAPE_OVERRUN)
            size = $urandom_range(1, 8);
         if (shape == SHAPE_TWIN && size < 3)
            size = 3;
         queue_matrix(shape, size, (k % 15) == 7);
         k++;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (rows_to_send.size() != 0 || req_if.valid)
         @(posedge clock);
      while (verdicts_due.size() != 0)
         @(posedge clock);
      // Keep running so that any stray verdict is caught.
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fails == 0) begin
         $display("PASS assignment_feasibility_check_unit");
      end else begin
         $display("FAIL assignment_feasibility_check_unit");
      end
      $finish;
   end

endmodule
